/* design/jbp_pkg.sv */
`default_nettype none

package jbp_pkg;

    localparam int SLOT_AW  = 6;
    localparam int DEPTH    = 2 ** SLOT_AW;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SEQ_W    = 32;
    localparam int TIME_W   = 64;
    localparam int HANDLE_W = 16;
    localparam int THR_W    = 7;
    localparam int SKIP_W   = 6;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    localparam logic [0:0] CMD_INSERT = 1'b0;
    localparam logic [0:0] CMD_FETCH  = 1'b1;

    localparam logic [0:0] REG_RESYNC_THR = 1'b0;
    localparam logic [0:0] REG_SKIP_THR   = 1'b1;

    localparam logic [THR_W-1:0] RESYNC_THR_RST = 7'd3;
    localparam logic [THR_W-1:0] SKIP_THR_RST   = 7'd2;

    typedef logic [SLOT_AW-1:0] t_idx;
    typedef logic [SLOT_AW:0]   t_iss;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef struct packed {
        logic [THR_W-1:0] resync_thr;
        logic [THR_W-1:0] skip_thr;
    } t_cfg;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [TIME_W-1:0]   release_time;
        logic [HANDLE_W-1:0] handle;
    } t_slot;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_slot wdata;
        t_idx  raddr;
    } t_ram_req;

    typedef struct packed {
        logic                taken;
        logic [SEQ_W-1:0]    out_seq;
        logic [HANDLE_W-1:0] out_handle;
        logic                resynced;
        logic [SKIP_W-1:0]   skipped;
    } t_res;

    // distance jumped over, clipped to what the skip field can show
    function automatic logic [SKIP_W-1:0] sat_skip(input t_idx i);
        logic [31:0] w;
        w = 32'(i);
        return (w > 32'd63) ? 6'd63 : w[SKIP_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/jbp_slot_ram.sv */
`default_nettype none

module jbp_slot_ram #(
    parameter int AW = 6,
    parameter int DW = 112
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/jbp_cfg.sv */
`default_nettype none

module jbp_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jbp_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [jbp_pkg::CFG_DW-1:0]  pwdata,
    output logic      [jbp_pkg::CFG_DW-1:0]  prdata,
    output logic                             pready,
    output jbp_pkg::t_cfg                    o_cfg
);

    logic [jbp_pkg::THR_W-1:0] r_resync_thr;
    logic [jbp_pkg::THR_W-1:0] r_skip_thr;
    logic [0:0]                w_sel;

    assign w_sel  = paddr[2:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resync_thr <= jbp_pkg::RESYNC_THR_RST;
            r_skip_thr   <= jbp_pkg::SKIP_THR_RST;
        end else if (psel && penable && pwrite) begin
            case (w_sel)
                jbp_pkg::REG_RESYNC_THR: r_resync_thr <= pwdata[jbp_pkg::THR_W-1:0];
                jbp_pkg::REG_SKIP_THR:   r_skip_thr   <= pwdata[jbp_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            jbp_pkg::REG_RESYNC_THR: prdata = jbp_pkg::CFG_DW'(r_resync_thr);
            jbp_pkg::REG_SKIP_THR:   prdata = jbp_pkg::CFG_DW'(r_skip_thr);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.resync_thr = r_resync_thr;
    assign o_cfg.skip_thr   = r_skip_thr;

endmodule

`default_nettype wire

/* design/jbp_engine.sv */
`default_nettype none

module jbp_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire jbp_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_cmd,
    input  wire logic [jbp_pkg::SEQ_W-1:0]     i_seq_number,
    input  wire logic [jbp_pkg::TIME_W-1:0]    i_release_time,
    input  wire logic [jbp_pkg::HANDLE_W-1:0]  i_handle,
    input  wire logic [jbp_pkg::TIME_W-1:0]    i_now_time,
    output jbp_pkg::t_ram_req                  o_ram_req,
    input  wire jbp_pkg::t_slot                i_ram_rdata,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output jbp_pkg::t_res                      o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_FETCH,
        S_CHK,
        S_MIN,
        S_SKIP,
        S_POST
    } t_state;

    t_state                       r_state;
    logic [jbp_pkg::DEPTH-1:0]    r_valid;
    jbp_pkg::t_cnt                r_cnt;
    logic [jbp_pkg::SEQ_W-1:0]    r_e;

    logic [jbp_pkg::SEQ_W-1:0]    r_seq;
    logic [jbp_pkg::TIME_W-1:0]   r_rel;
    logic [jbp_pkg::HANDLE_W-1:0] r_handle;
    logic [jbp_pkg::TIME_W-1:0]   r_now;

    // scan issue counter and the read issued in the previous cycle
    jbp_pkg::t_iss                r_iss;
    logic                         r_p_v;
    jbp_pkg::t_idx                r_p_i;
    logic [jbp_pkg::SEQ_W-1:0]    r_p_cs;
    logic                         r_found;
    logic [jbp_pkg::SEQ_W-1:0]    r_mn;

    jbp_pkg::t_res                r_res;
    logic                         r_o_valid;
    jbp_pkg::t_res                r_o_res;

    jbp_pkg::t_idx                w_idx;
    jbp_pkg::t_idx                w_sidx;
    logic                         w_due;
    logic                         w_resync;
    logic                         w_skip_ok;
    logic                         w_min_upd;
    logic                         w_skip_hit;
    logic                         w_last;
    logic                         w_found_f;
    logic [jbp_pkg::SEQ_W-1:0]    w_mn_f;

    assign w_idx     = r_e[jbp_pkg::SLOT_AW-1:0];
    assign w_sidx    = r_seq[jbp_pkg::SLOT_AW-1:0];
    assign w_due     = r_now >= i_ram_rdata.release_time;
    assign w_resync  = (32'(r_cnt) > 32'(i_cfg.resync_thr)) && !r_valid[w_idx];
    assign w_skip_ok = 32'(r_cnt) > 32'(i_cfg.skip_thr);
    assign w_last    = r_p_v && (&r_p_i);
    assign w_min_upd = r_p_v && r_valid[r_p_i] && (!r_found || i_ram_rdata.seq < r_mn);
    assign w_found_f = r_found || w_min_upd;
    assign w_mn_f    = w_min_upd ? i_ram_rdata.seq : r_mn;
    assign w_skip_hit = r_p_v && r_valid[r_p_cs[jbp_pkg::SLOT_AW-1:0]]
                        && (i_ram_rdata.seq == r_p_cs);

    always_comb begin
        o_ram_req.we                 = (r_state == S_INS);
        o_ram_req.waddr              = w_sidx;
        o_ram_req.wdata.seq          = r_seq;
        o_ram_req.wdata.release_time = r_rel;
        o_ram_req.wdata.handle       = r_handle;
        case (r_state)
            S_MIN:   o_ram_req.raddr = r_iss[jbp_pkg::SLOT_AW-1:0];
            S_SKIP:  o_ram_req.raddr = w_idx + r_iss[jbp_pkg::SLOT_AW-1:0];
            default: o_ram_req.raddr = w_idx;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_res       = r_o_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_e       <= '0;
            r_iss     <= '0;
            r_p_v     <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_out_stall && r_state != S_POST) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_seq    <= i_seq_number;
                        r_rel    <= i_release_time;
                        r_handle <= i_handle;
                        r_now    <= i_now_time;
                        r_state  <= (i_cmd == jbp_pkg::CMD_FETCH) ? S_FETCH : S_INS;
                    end
                end
                S_INS: begin
                    if (!r_valid[w_sidx]) begin
                        r_cnt <= r_cnt + jbp_pkg::t_cnt'(1);
                    end
                    r_valid[w_sidx] <= 1'b1;
                    r_res   <= '0;
                    r_state <= S_POST;
                end
                S_FETCH: begin
                    r_res <= '0;
                    if (w_resync) begin
                        r_iss   <= '0;
                        r_p_v   <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_MIN;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_valid[w_idx] && i_ram_rdata.seq == r_e) begin
                        if (w_due) begin
                            r_valid[w_idx]   <= 1'b0;
                            r_e              <= r_e + 32'd1;
                            r_cnt            <= r_cnt - jbp_pkg::t_cnt'(1);
                            r_res.taken      <= 1'b1;
                            r_res.out_seq    <= i_ram_rdata.seq;
                            r_res.out_handle <= i_ram_rdata.handle;
                        end
                        r_state <= S_POST;
                    end else if (w_skip_ok) begin
                        r_iss   <= '0;
                        r_p_v   <= 1'b0;
                        r_state <= S_SKIP;
                    end else begin
                        r_state <= S_POST;
                    end
                end
                S_MIN: begin
                    if (!r_iss[jbp_pkg::SLOT_AW]) begin
                        r_iss <= r_iss + jbp_pkg::t_iss'(1);
                        r_p_v <= 1'b1;
                        r_p_i <= r_iss[jbp_pkg::SLOT_AW-1:0];
                    end else begin
                        r_p_v <= 1'b0;
                    end
                    if (w_min_upd) begin
                        r_found <= 1'b1;
                        r_mn    <= i_ram_rdata.seq;
                    end
                    if (w_last) begin
                        if (w_found_f) begin
                            r_e            <= w_mn_f;
                            r_res.resynced <= 1'b1;
                        end
                        // old expected slot was empty, so only the scan can take
                        if (w_skip_ok) begin
                            r_iss   <= '0;
                            r_state <= S_SKIP;
                        end else begin
                            r_state <= S_POST;
                        end
                    end
                end
                S_SKIP: begin
                    if (w_skip_hit) begin
                        if (w_due) begin
                            r_valid[r_p_cs[jbp_pkg::SLOT_AW-1:0]] <= 1'b0;
                            r_e              <= r_p_cs + 32'd1;
                            r_cnt            <= r_cnt - jbp_pkg::t_cnt'(1);
                            r_res.taken      <= 1'b1;
                            r_res.out_seq    <= r_p_cs;
                            r_res.out_handle <= i_ram_rdata.handle;
                            r_res.skipped    <= jbp_pkg::sat_skip(r_p_i);
                        end
                        r_p_v   <= 1'b0;
                        r_state <= S_POST;
                    end else begin
                        if (!r_iss[jbp_pkg::SLOT_AW]) begin
                            r_iss  <= r_iss + jbp_pkg::t_iss'(1);
                            r_p_v  <= 1'b1;
                            r_p_i  <= r_iss[jbp_pkg::SLOT_AW-1:0];
                            r_p_cs <= r_e + 32'(r_iss);
                        end else begin
                            r_p_v <= 1'b0;
                        end
                        if (w_last) begin
                            r_state <= S_POST;
                        end
                    end
                end
                S_POST: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_res   <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/jitter_buffer_playout_top.sv */
// insert: passes S_INS and S_POST before the result is registered; fetch of the expected slot: S_FETCH, S_CHK, S_POST
// forward skip scan: one slot memory read per cycle, over up to DEPTH offsets from the expected sequence
// resync: a minimum sweep over all DEPTH slots through the same read port
// one transaction in work at a time; the next is accepted while a result waits
// reset: synchronous, clears valid bits, count and expected sequence at once; no clearing pass
`default_nettype none

module jitter_buffer_playout_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jbp_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [jbp_pkg::CFG_DW-1:0]    pwdata,
    output logic      [jbp_pkg::CFG_DW-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_cmd,
    input  wire logic [jbp_pkg::SEQ_W-1:0]     i_seq_number,
    input  wire logic [jbp_pkg::TIME_W-1:0]    i_release_time,
    input  wire logic [jbp_pkg::HANDLE_W-1:0]  i_handle,
    input  wire logic [jbp_pkg::TIME_W-1:0]    i_now_time,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_taken,
    output logic      [jbp_pkg::SEQ_W-1:0]     o_out_seq,
    output logic      [jbp_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic                               o_resynced,
    output logic      [jbp_pkg::SKIP_W-1:0]    o_skipped
);

    jbp_pkg::t_cfg     w_cfg;
    jbp_pkg::t_ram_req w_ram_req;
    jbp_pkg::t_slot    w_ram_rdata;
    jbp_pkg::t_res     w_res;

    jbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    jbp_slot_ram #(
        .AW (jbp_pkg::SLOT_AW),
        .DW ($bits(jbp_pkg::t_slot))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_req.we),
        .i_waddr (w_ram_req.waddr),
        .i_wdata (w_ram_req.wdata),
        .i_raddr (w_ram_req.raddr),
        .o_rdata (w_ram_rdata)
    );

    jbp_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_seq_number   (i_seq_number),
        .i_release_time (i_release_time),
        .i_handle       (i_handle),
        .i_now_time     (i_now_time),
        .o_ram_req      (w_ram_req),
        .i_ram_rdata    (w_ram_rdata),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_res          (w_res)
    );

    assign o_taken      = w_res.taken;
    assign o_out_seq    = w_res.out_seq;
    assign o_out_handle = w_res.out_handle;
    assign o_resynced   = w_res.resynced;
    assign o_skipped    = w_res.skipped;

endmodule

`default_nettype wire
